@@ src/grc_pkg.sv @@
// grc_pkg: shared types and constants for the grid region majority counter
// cell codes, register indexes, state and direction encodings, bus widths
// no dependencies
`default_nettype none

package grc_pkg;

  localparam int unsigned DEF_MAX_ROWS    = 256;
  localparam int unsigned DEF_MAX_COLUMNS = 256;
  localparam int unsigned DEF_DIM         = 256;

  localparam int unsigned CODE_W      = 2;
  localparam int unsigned TOTAL_W     = 17;
  localparam int unsigned CFG_DATA_W  = 9;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - 2 * TOTAL_W;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = CFG_IDX_W'(1);

  typedef enum logic [CODE_W-1:0] {
    CODE_EMPTY = 2'd0,
    CODE_WALL  = 2'd1,
    CODE_SHEEP = 2'd2,
    CODE_WOLF  = 2'd3
  } cell_code_e;

  typedef struct packed {
    logic       visited;
    cell_code_e code;
  } cell_entry_t;

  localparam int unsigned CELL_W = $bits(cell_entry_t);

  typedef enum logic [7:0] {
    S_LOAD      = 8'b0000_0001,
    S_TAIL      = 8'b0000_0010,
    S_START     = 8'b0000_0100,
    S_START_CHK = 8'b0000_1000,
    S_POP       = 8'b0001_0000,
    S_CUR       = 8'b0010_0000,
    S_SCAN      = 8'b0100_0000,
    S_DONE      = 8'b1000_0000
  } fsm_e;

  typedef enum logic [2:0] {
    DIR_UP    = 3'd0,
    DIR_LEFT  = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_RIGHT = 3'd3,
    DIR_END   = 3'd4
  } dir_e;

endpackage

`default_nettype wire

@@ src/grc_ram.sv @@
// grc_ram: generic simple dual-port ram, one write and one read port
// read data is registered; no dependencies
`default_nettype none

module grc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/grid_region_majority_count.sv @@
// grid_region_majority_count: loads a grid of cell codes, flood-fills 4-connected
// open regions with a stack in ram and emits surviving sheep and wolf totals
// depends on grc_pkg and grc_ram
//
//  port group     dir   beat contents
//  s_axis_*       in    tdata[1:0] cell_code, tlast last_cell
//  m_axis_*       out   tdata[16:0] surviving_sheep, tdata[33:17] surviving_wolves
//  cfg_*          in    write of row_count (index 0) or column_count (index 1)
//
//  loading accepts one cell beat per cycle; tready is low from the last cell until the
//  result is loaded into the output register
//  after the last cell: the missing cells are written as empty, every grid cell gets a
//  start read and check, every open cell is popped, fetched, its four neighbors read and
//  the last one drained, every region closes with a pop of the empty stack, and the
//  totals are handed over; the single read port of the cell ram sets this pace
//  no clearing pass after reset: every cell of a grid is rewritten before the fill
//  a result waits in the output register while the next grid is loaded
`default_nettype none

module grid_region_majority_count #(
  parameter int unsigned MAX_ROWS    = grc_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLUMNS = grc_pkg::DEF_MAX_COLUMNS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [grc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [1:0] cell_code
  input  logic                              s_axis_tlast,   // last_cell
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [grc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [16:0] surviving_sheep,
                                                            // [33:17] surviving_wolves
  input  logic                              cfg_we_i,
  input  logic [grc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [grc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  import grc_pkg::*;

  localparam int unsigned CAP      = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned AW       = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int unsigned PNW      = $clog2(CAP + 1);
  localparam int unsigned RNW      = $clog2(MAX_ROWS + 1);
  localparam int unsigned CNW      = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned RST_ROWS = (DEF_DIM > MAX_ROWS) ? MAX_ROWS : DEF_DIM;
  localparam int unsigned RST_COLS = (DEF_DIM > MAX_COLUMNS) ? MAX_COLUMNS : DEF_DIM;
  localparam int unsigned RST_SIZE = RST_ROWS * RST_COLS;

  typedef struct packed {
    cell_code_e     code;
    logic [RNW-1:0] row;
    logic [CNW-1:0] col;
    logic [AW-1:0]  pos;
  } stk_entry_t;

  localparam int unsigned STK_W = $bits(stk_entry_t);

  function automatic logic [RNW-1:0] clamp_rows(logic [CFG_DATA_W-1:0] v);
    logic [RNW-1:0] r;
    if (v == '0) r = RNW'(1);
    else if (32'(v) > MAX_ROWS) r = RNW'(MAX_ROWS);
    else r = RNW'(v);
    return r;
  endfunction

  function automatic logic [CNW-1:0] clamp_cols(logic [CFG_DATA_W-1:0] v);
    logic [CNW-1:0] c;
    if (v == '0) c = CNW'(1);
    else if (32'(v) > MAX_COLUMNS) c = CNW'(MAX_COLUMNS);
    else c = CNW'(v);
    return c;
  endfunction

  // geometry
  logic [RNW-1:0] rows_q, rows_d;
  logic [CNW-1:0] cols_q, cols_d;
  logic [PNW-1:0] size_q, size_d;

  // control
  fsm_e           state_q, state_d;
  logic [PNW-1:0] load_pos_q, load_pos_d;
  logic [PNW-1:0] sp_q, sp_d;
  logic [AW-1:0]  start_pos_q, start_pos_d;
  logic [RNW-1:0] start_row_q, start_row_d;
  logic [CNW-1:0] start_col_q, start_col_d;
  dir_e           dir_q, dir_d;
  logic           nb_pend_q, nb_pend_d;
  logic [PNW-1:0] reg_sheep_q, reg_sheep_d;
  logic [PNW-1:0] reg_wolves_q, reg_wolves_d;
  logic [TOTAL_W-1:0] sheep_tot_q, sheep_tot_d;
  logic [TOTAL_W-1:0] wolf_tot_q, wolf_tot_d;
  logic           out_valid_q, out_valid_d;
  logic           advance;

  // payload
  stk_entry_t         cur_q, cur_d;
  stk_entry_t         nb_q, nb_d;
  logic [TOTAL_W-1:0] out_sheep_q, out_sheep_d;
  logic [TOTAL_W-1:0] out_wolves_q, out_wolves_d;

  // ram ports
  logic        cell_we;
  logic [AW-1:0] cell_waddr, cell_raddr;
  cell_entry_t cell_wdata, cell_rdata;
  logic        stk_we;
  logic [AW-1:0] stk_waddr, stk_raddr;
  stk_entry_t  stk_wdata, stk_rdata;

  grc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CAP)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  grc_ram #(
    .WIDTH (STK_W),
    .DEPTH (CAP)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROW_COUNT:    rows_d = clamp_rows(cfg_data_i);
        REG_COLUMN_COUNT: cols_d = clamp_cols(cfg_data_i);
        default: ;
      endcase
    end
    size_d = PNW'(PNW'(rows_d) * PNW'(cols_d));
  end

  always_comb begin
    state_d      = state_q;
    load_pos_d   = load_pos_q;
    sp_d         = sp_q;
    start_pos_d  = start_pos_q;
    start_row_d  = start_row_q;
    start_col_d  = start_col_q;
    dir_d        = dir_q;
    nb_pend_d    = nb_pend_q;
    reg_sheep_d  = reg_sheep_q;
    reg_wolves_d = reg_wolves_q;
    sheep_tot_d  = sheep_tot_q;
    wolf_tot_d   = wolf_tot_q;
    out_valid_d  = out_valid_q;
    out_sheep_d  = out_sheep_q;
    out_wolves_d = out_wolves_q;
    cur_d        = cur_q;
    nb_d         = nb_q;
    advance      = 1'b0;

    cell_we    = 1'b0;
    cell_waddr = start_pos_q;
    cell_wdata = '{visited: 1'b0, code: CODE_EMPTY};
    cell_raddr = start_pos_q;
    stk_we     = 1'b0;
    stk_waddr  = sp_q[AW-1:0];
    stk_wdata  = nb_q;
    stk_raddr  = sp_q[AW-1:0];

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_LOAD: begin
        if (s_axis_tvalid) begin
          if (load_pos_q < size_q) begin
            cell_we    = 1'b1;
            cell_waddr = load_pos_q[AW-1:0];
            cell_wdata = '{visited: 1'b0, code: cell_code_e'(s_axis_tdata[CODE_W-1:0])};
            load_pos_d = load_pos_q + PNW'(1);
          end
          if (s_axis_tlast) begin
            state_d = S_TAIL;
          end
        end
      end
      // cells missing from a short grid are stored as empty
      S_TAIL: begin
        if (load_pos_q < size_q) begin
          cell_we    = 1'b1;
          cell_waddr = load_pos_q[AW-1:0];
          cell_wdata = '{visited: 1'b0, code: CODE_EMPTY};
          load_pos_d = load_pos_q + PNW'(1);
        end else begin
          state_d = S_START;
        end
      end
      S_START: begin
        cell_raddr = start_pos_q;
        state_d    = S_START_CHK;
      end
      S_START_CHK: begin
        if (!cell_rdata.visited && cell_rdata.code != CODE_WALL) begin
          cell_we      = 1'b1;
          cell_waddr   = start_pos_q;
          cell_wdata   = '{visited: 1'b1, code: cell_rdata.code};
          stk_we       = 1'b1;
          stk_waddr    = sp_q[AW-1:0];
          stk_wdata    = '{code: cell_rdata.code, row: start_row_q,
                           col: start_col_q, pos: start_pos_q};
          sp_d         = sp_q + PNW'(1);
          reg_sheep_d  = '0;
          reg_wolves_d = '0;
          state_d      = S_POP;
        end else begin
          advance = 1'b1;
        end
      end
      S_POP: begin
        if (sp_q != '0) begin
          stk_raddr = AW'(sp_q - PNW'(1));
          sp_d      = sp_q - PNW'(1);
          state_d   = S_CUR;
        end else begin
          if (reg_sheep_q > reg_wolves_q) begin
            sheep_tot_d = sheep_tot_q + TOTAL_W'(reg_sheep_q);
          end else begin
            wolf_tot_d = wolf_tot_q + TOTAL_W'(reg_wolves_q);
          end
          advance = 1'b1;
        end
      end
      S_CUR: begin
        cur_d = stk_rdata;
        if (stk_rdata.code == CODE_SHEEP) begin
          reg_sheep_d = reg_sheep_q + PNW'(1);
        end else if (stk_rdata.code == CODE_WOLF) begin
          reg_wolves_d = reg_wolves_q + PNW'(1);
        end
        dir_d     = DIR_UP;
        nb_pend_d = 1'b0;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        // previous neighbor: mark and push if open and unseen
        if (nb_pend_q && !cell_rdata.visited && cell_rdata.code != CODE_WALL) begin
          cell_we        = 1'b1;
          cell_waddr     = nb_q.pos;
          cell_wdata     = '{visited: 1'b1, code: cell_rdata.code};
          stk_we         = 1'b1;
          stk_waddr      = sp_q[AW-1:0];
          stk_wdata      = nb_q;
          stk_wdata.code = cell_rdata.code;
          sp_d           = sp_q + PNW'(1);
        end
        nb_d      = cur_q;
        nb_pend_d = 1'b0;
        case (dir_q)
          DIR_UP: begin
            nb_d.row  = cur_q.row - RNW'(1);
            nb_d.pos  = cur_q.pos - AW'(cols_q);
            nb_pend_d = (cur_q.row != '0);
            dir_d     = DIR_LEFT;
          end
          DIR_LEFT: begin
            nb_d.col  = cur_q.col - CNW'(1);
            nb_d.pos  = cur_q.pos - AW'(1);
            nb_pend_d = (cur_q.col != '0);
            dir_d     = DIR_DOWN;
          end
          DIR_DOWN: begin
            nb_d.row  = cur_q.row + RNW'(1);
            nb_d.pos  = cur_q.pos + AW'(cols_q);
            nb_pend_d = ({1'b0, cur_q.row} + (RNW + 1)'(1)) < {1'b0, rows_q};
            dir_d     = DIR_RIGHT;
          end
          DIR_RIGHT: begin
            nb_d.col  = cur_q.col + CNW'(1);
            nb_d.pos  = cur_q.pos + AW'(1);
            nb_pend_d = ({1'b0, cur_q.col} + (CNW + 1)'(1)) < {1'b0, cols_q};
            dir_d     = DIR_END;
          end
          default: begin
            state_d = S_POP;
          end
        endcase
        cell_raddr = nb_d.pos;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_sheep_d  = sheep_tot_q;
          out_wolves_d = wolf_tot_q;
          sheep_tot_d  = '0;
          wolf_tot_d   = '0;
          load_pos_d   = '0;
          state_d      = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase

    // next start cell of the raster sweep
    if (advance) begin
      if (PNW'(start_pos_q) + PNW'(1) == size_q) begin
        start_pos_d = '0;
        start_row_d = '0;
        start_col_d = '0;
        state_d     = S_DONE;
      end else begin
        start_pos_d = start_pos_q + AW'(1);
        if (start_col_q + CNW'(1) == cols_q) begin
          start_col_d = '0;
          start_row_d = start_row_q + RNW'(1);
        end else begin
          start_col_d = start_col_q + CNW'(1);
        end
        state_d = S_START;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q       <= RNW'(RST_ROWS);
      cols_q       <= CNW'(RST_COLS);
      size_q       <= PNW'(RST_SIZE);
      state_q      <= S_LOAD;
      load_pos_q   <= '0;
      sp_q         <= '0;
      start_pos_q  <= '0;
      start_row_q  <= '0;
      start_col_q  <= '0;
      dir_q        <= DIR_UP;
      nb_pend_q    <= 1'b0;
      reg_sheep_q  <= '0;
      reg_wolves_q <= '0;
      sheep_tot_q  <= '0;
      wolf_tot_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      rows_q       <= rows_d;
      cols_q       <= cols_d;
      size_q       <= size_d;
      state_q      <= state_d;
      load_pos_q   <= load_pos_d;
      sp_q         <= sp_d;
      start_pos_q  <= start_pos_d;
      start_row_q  <= start_row_d;
      start_col_q  <= start_col_d;
      dir_q        <= dir_d;
      nb_pend_q    <= nb_pend_d;
      reg_sheep_q  <= reg_sheep_d;
      reg_wolves_q <= reg_wolves_d;
      sheep_tot_q  <= sheep_tot_d;
      wolf_tot_q   <= wolf_tot_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    nb_q         <= nb_d;
    out_sheep_q  <= out_sheep_d;
    out_wolves_q <= out_wolves_d;
  end

  assign s_axis_tready = (state_q == S_LOAD);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_wolves_q, out_sheep_q};

  a_load_stack_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> (sp_q == '0))
    else $error("stack not empty while loading");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= PNW'(CAP))
    else $error("stack pointer beyond capacity");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done state");

  a_push_needs_neighbor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && stk_we) |-> nb_pend_q)
    else $error("push of a neighbor that was never read");

endmodule

`default_nettype wire

@@ verif/region_totals_checker.sv @@
`timescale 1ns / 100ps
// region_totals_checker: watches the cell, totals and register ports of the block,
// predicts the sheep and wolf totals of every grid and compares each totals beat
// depends on grc_pkg
module region_totals_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [grc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [1:0] cell_code
  input  logic                            s_axis_tlast,   // last_cell
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [grc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [16:0] surviving_sheep,
                                                          // [33:17] surviving_wolves
  input  logic                            cfg_we_i,
  input  logic [grc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [grc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int                              mismatch_count_o,
  output int                              totals_seen_o,
  output int                              totals_waiting_o
);

  import grc_pkg::*;

  localparam int unsigned CAPACITY = DEF_MAX_ROWS * DEF_MAX_COLUMNS;

  typedef struct packed {
    logic [TOTAL_W-1:0] wolves;
    logic [TOTAL_W-1:0] sheep;
  } totals_t;

  cell_code_e            grid_cells [CAPACITY];
  bit                    seen_map [CAPACITY];
  int unsigned           walk [CAPACITY];
  logic [CFG_DATA_W-1:0] rows_reg;
  logic [CFG_DATA_W-1:0] cols_reg;
  int unsigned           cells_loaded;
  totals_t               pending_totals [$];

  function automatic int unsigned dim_in_use(input logic [CFG_DATA_W-1:0] raw,
                                             input int unsigned limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  // cells past the loaded count read as empty
  function automatic cell_code_e cell_in_grid(input int unsigned pos,
                                              input int unsigned loaded);
    if (pos >= loaded) return CODE_EMPTY;
    return grid_cells[pos];
  endfunction

  function automatic totals_t count_survivors(input int unsigned rows,
                                              input int unsigned cols,
                                              input int unsigned loaded);
    int unsigned area, start, here, depth, herd, pack, row, col;
    int unsigned near [4];
    int          n_near, k;
    logic [31:0] sheep_sum, wolf_sum;
    cell_code_e  code;
    totals_t     sums;
    area = rows * cols;
    sheep_sum = 0;
    wolf_sum = 0;
    for (start = 0; start < area; start++) seen_map[start] = 1'b0;
    for (start = 0; start < area; start++) begin
      if (!seen_map[start] && cell_in_grid(start, loaded) != CODE_WALL) begin
        seen_map[start] = 1'b1;
        walk[0] = start;
        depth = 1;
        herd = 0;
        pack = 0;
        while (depth > 0) begin
          depth--;
          here = walk[depth];
          code = cell_in_grid(here, loaded);
          if (code == CODE_SHEEP) herd++;
          else if (code == CODE_WOLF) pack++;
          row = here / cols;
          col = here % cols;
          n_near = 0;
          if (row > 0) begin
            near[n_near] = here - cols;
            n_near++;
          end
          if (col > 0) begin
            near[n_near] = here - 1;
            n_near++;
          end
          if (row + 1 < rows) begin
            near[n_near] = here + cols;
            n_near++;
          end
          if (col + 1 < cols) begin
            near[n_near] = here + 1;
            n_near++;
          end
          for (k = 0; k < n_near; k++) begin
            if (!seen_map[near[k]] && cell_in_grid(near[k], loaded) != CODE_WALL) begin
              seen_map[near[k]] = 1'b1;
              walk[depth] = near[k];
              depth++;
            end
          end
        end
        // ties go to the wolves
        if (herd > pack) sheep_sum += herd;
        else wolf_sum += pack;
      end
    end
    sums.sheep = sheep_sum[TOTAL_W-1:0];
    sums.wolves = wolf_sum[TOTAL_W-1:0];
    return sums;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    totals_t            want;
    logic [TOTAL_W-1:0] got_sheep, got_wolves;
    int                 errs, seen_now;
    int unsigned        rows_eff, cols_eff;
    errs = 0;
    seen_now = 0;
    if (!rst_ni) begin
      pending_totals.delete();
      rows_reg = CFG_DATA_W'(DEF_DIM);
      cols_reg = CFG_DATA_W'(DEF_DIM);
      cells_loaded = 0;
      mismatch_count_o <= 0;
      totals_seen_o <= 0;
      totals_waiting_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_sheep = m_axis_tdata[TOTAL_W-1:0];
        got_wolves = m_axis_tdata[2*TOTAL_W-1:TOTAL_W];
        seen_now = 1;
        if (pending_totals.size() == 0) begin
          $display("%0t: totals beat with none expected, got sheep %0d wolves %0d",
                   $time, got_sheep, got_wolves);
          errs++;
        end else begin
          want = pending_totals.pop_front();
          if (got_sheep !== want.sheep) begin
            $display("%0t: surviving_sheep expected %0d, got %0d",
                     $time, want.sheep, got_sheep);
            errs++;
          end
          if (got_wolves !== want.wolves) begin
            $display("%0t: surviving_wolves expected %0d, got %0d",
                     $time, want.wolves, got_wolves);
            errs++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_ROW_COUNT) rows_reg = cfg_data_i;
        else if (cfg_idx_i == REG_COLUMN_COUNT) cols_reg = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        rows_eff = dim_in_use(rows_reg, DEF_MAX_ROWS);
        cols_eff = dim_in_use(cols_reg, DEF_MAX_COLUMNS);
        // surplus cells beyond the grid are dropped
        if (cells_loaded < rows_eff * cols_eff) begin
          grid_cells[cells_loaded] = cell_code_e'(s_axis_tdata[CODE_W-1:0]);
          cells_loaded++;
        end
        if (s_axis_tlast) begin
          pending_totals.insert(pending_totals.size(),
                                count_survivors(rows_eff, cols_eff, cells_loaded));
          cells_loaded = 0;
        end
      end
      mismatch_count_o <= mismatch_count_o + errs;
      totals_seen_o <= totals_seen_o + seen_now;
      totals_waiting_o <= pending_totals.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// testbench: drives cell grids and register writes into grid_region_majority_count
// and gives the verdict from the mismatch and pending totals counts of region_totals_checker
// depends on grc_pkg, grid_region_majority_count and region_totals_checker
module testbench;
  import grc_pkg::*;

  localparam int unsigned ITEM_TARGET   = 2000;
  localparam int unsigned QUIET_FROM    = 1700;
  localparam int unsigned HOLD_FROM     = 600;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned STALL_LIMIT   = 30000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 40;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [1:0] cell_code
  logic                   s_axis_tlast;   // last_cell
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [16:0] surviving_sheep, [33:17] surviving_wolves
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  int          mismatch_count;
  int          totals_seen;
  int          totals_waiting;
  int unsigned grids_sent;
  int unsigned cells_sent;
  int unsigned grid_size;
  int unsigned stalled_cycles;
  bit          gaps_on = 1'b1;
  bit          burst_gaps = 1'b1;
  bit          hold_request;

  grid_region_majority_count uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  region_totals_checker totals_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .totals_seen_o    (totals_seen),
    .totals_waiting_o (totals_waiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // totals receiver
  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (gaps_on && $urandom_range(7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(13, 1)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_cell(input cell_code_e code, input bit last);
    if (gaps_on && burst_gaps && $urandom_range(5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(13, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_TDATA_W'(code);
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    cells_sent++;
    if (last) grids_sent++;
  endtask

  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (totals_seen != grids_sent);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] rows_raw,
                           input logic [CFG_DATA_W-1:0] cols_raw);
    int unsigned rows_eff, cols_eff;
    rows_eff = (rows_raw == 0) ? 1 : ((rows_raw > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows_raw);
    cols_eff = (cols_raw == 0) ? 1 :
               ((cols_raw > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : cols_raw);
    grid_size = rows_eff * cols_eff;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_ROW_COUNT;
    cfg_data_i <= rows_raw;
    @(posedge clk_i);
    cfg_idx_i <= REG_COLUMN_COUNT;
    cfg_data_i <= cols_raw;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random_grid();
    int unsigned count, wall_pct, shape, k;
    cell_code_e  code;
    shape = $urandom_range(9);
    if (shape == 0 && grid_size > 1) count = $urandom_range(grid_size - 1, 1);
    else if (shape == 1) count = grid_size + $urandom_range(5, 1);
    else count = grid_size;
    wall_pct = $urandom_range(4) * 15;
    for (k = 1; k <= count; k++) begin
      if ($urandom_range(99) < wall_pct) begin
        code = CODE_WALL;
      end else begin
        case ($urandom_range(2))
          0: code = CODE_EMPTY;
          1: code = CODE_SHEEP;
          default: code = CODE_WOLF;
        endcase
      end
      send_cell(code, k == count);
    end
  endtask

  initial begin
    int unsigned pick, grids, g;
    bit          hold_done;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_ROW_COUNT;
    cfg_data_i = '0;
    hold_done = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single cell grids, one per code
    configure(9'd1, 9'd1);
    send_cell(CODE_SHEEP, 1'b1);
    send_cell(CODE_WOLF, 1'b1);
    send_cell(CODE_WALL, 1'b1);
    send_cell(CODE_EMPTY, 1'b1);
    finish_phase();

    configure(9'd2, 9'd2);
    // one sheep against one wolf: tie
    send_cell(CODE_SHEEP, 1'b0);
    send_cell(CODE_WOLF, 1'b0);
    send_cell(CODE_EMPTY, 1'b0);
    send_cell(CODE_WALL, 1'b1);
    // walls split the sheep from the wolf
    send_cell(CODE_SHEEP, 1'b0);
    send_cell(CODE_WALL, 1'b0);
    send_cell(CODE_WALL, 1'b0);
    send_cell(CODE_WOLF, 1'b1);
    finish_phase();

    // zero rows and oversize columns, grid closed early
    configure(9'd0, 9'd511);
    send_cell(CODE_WOLF, 1'b0);
    send_cell(CODE_SHEEP, 1'b0);
    send_cell(CODE_SHEEP, 1'b1);
    finish_phase();

    configure(9'd256, 9'd1);
    send_cell(CODE_SHEEP, 1'b0);
    send_cell(CODE_WALL, 1'b0);
    send_cell(CODE_WOLF, 1'b1);
    finish_phase();

    // surplus cells before the last one
    configure(9'd1, 9'd2);
    send_cell(CODE_WOLF, 1'b0);
    send_cell(CODE_WOLF, 1'b0);
    send_cell(CODE_SHEEP, 1'b0);
    send_cell(CODE_SHEEP, 1'b0);
    send_cell(CODE_SHEEP, 1'b1);
    finish_phase();

    while (cells_sent < ITEM_TARGET) begin
      if (cells_sent >= QUIET_FROM) gaps_on = 1'b0;
      burst_gaps = ($urandom_range(3) != 0);
      pick = $urandom_range(11);
      if (!hold_done && cells_sent >= HOLD_FROM) begin
        // receiver stalls while grids keep coming
        hold_done = 1'b1;
        burst_gaps = 1'b0;
        configure(CFG_DATA_W'($urandom_range(4, 2)), CFG_DATA_W'($urandom_range(4, 2)));
        hold_request = 1'b1;
        grids = 6;
      end else if (pick == 0) begin
        configure(CFG_DATA_W'($urandom_range(511, 256)), CFG_DATA_W'($urandom_range(1)));
        grids = $urandom_range(2, 1);
      end else if (pick == 1) begin
        configure(CFG_DATA_W'($urandom_range(1)), CFG_DATA_W'($urandom_range(511, 256)));
        grids = $urandom_range(2, 1);
      end else if (pick == 2) begin
        configure(CFG_DATA_W'($urandom_range(16, 9)), CFG_DATA_W'($urandom_range(16, 9)));
        grids = $urandom_range(2, 1);
      end else begin
        configure(CFG_DATA_W'($urandom_range(8, 1)), CFG_DATA_W'($urandom_range(8, 1)));
        grids = $urandom_range(6, 1);
      end
      for (g = 0; g < grids; g++) send_random_grid();
      finish_phase();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && totals_waiting == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/grc_pkg.sv
src/grc_ram.sv
src/grid_region_majority_count.sv
verif/region_totals_checker.sv
verif/testbench.sv
